// ----- rtl/salsa_pkg.sv -----
`default_nettype none

package salsa_pkg;

   // One 32-bit word, a lane of four words, the state held as four lanes,
   // and the state held as sixteen words in matrix order.
   typedef logic [31:0]    word_type;
   typedef word_type [3:0] lane_type;
   typedef lane_type [3:0] quad_type;
   typedef word_type [15:0] block_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FINAL,
      ST_EMIT
   } state_type;

   // Rotation amounts of the four steps of a quarter round.
   typedef enum logic [1:0] {
      ROT_7,
      ROT_9,
      ROT_13,
      ROT_18
   } rot_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic    load;
      logic    round_step;
      logic    final_step;
      logic    permute;
      rot_type rot;
   } core_ctrl_type;

   // Requests from the top level to the sequencer.
   typedef struct packed {
      logic accept;
      logic need_build;
      logic slot_free;
   } seq_in_type;

   // Status from the sequencer to the top level.
   typedef struct packed {
      logic busy;
      logic emit;
      logic block_done;
   } seq_out_type;

   // Key layout codes.
   localparam logic [1:0] KEY_MODE_64  = 2'd0;
   localparam logic [1:0] KEY_MODE_128 = 2'd1;
   localparam logic [1:0] KEY_MODE_256 = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_KEY_MODE = 3'd0;
   localparam logic [2:0] REG_KEY_01   = 3'd1;
   localparam logic [2:0] REG_KEY_23   = 3'd2;
   localparam logic [2:0] REG_KEY_45   = 3'd3;
   localparam logic [2:0] REG_KEY_67   = 3'd4;
   localparam logic [2:0] REG_NONCE    = 3'd5;

   // Constant words of the state, in text byte order.
   localparam word_type SIGMA_0 = 32'h65787061;
   localparam word_type SIGMA_3 = 32'h7465206B;
   localparam word_type C1_64   = 32'h6E642030;
   localparam word_type C2_64   = 32'h382D6279;
   localparam word_type C1_128  = 32'h6E642031;
   localparam word_type C2_128  = 32'h362D6279;
   localparam word_type C1_256  = 32'h6E642033;
   localparam word_type C2_256  = 32'h322D6279;

   // Reverses the byte order of a word.
   function automatic word_type bswap32(input word_type w);
      return {w[7:0], w[15:8], w[23:16], w[31:24]};
   endfunction

   // Rotates a word left by the amount of the given step.
   function automatic word_type rotl_sel(input word_type v, input rot_type rot);
      word_type r;
      unique case (rot)
         ROT_7:   r = {v[24:0], v[31:25]};
         ROT_9:   r = {v[22:0], v[31:23]};
         ROT_13:  r = {v[18:0], v[31:19]};
         ROT_18:  r = {v[13:0], v[31:14]};
         default: r = v;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/salsa_core.sv -----
`default_nettype none

// State datapath: four lanes of add, rotate and xor, shared by every quarter
// round step and by the final feed-forward addition. Lane l holds the words
// of one quarter round in the order a, b, c, d. After each step the roles
// move on by one place, so the same wiring serves all four steps. After a
// half round a fixed permutation turns the column layout into the row layout
// and back again.
module salsa_core (
   input  wire                           clock,
   input  wire salsa_pkg::core_ctrl_type ctrl,
   input  wire salsa_pkg::block_type     init_block,
   input  wire [3:0]                     rd_index,
   output salsa_pkg::word_type           rd_word
);

   salsa_pkg::quad_type q_ff;
   salsa_pkg::quad_type q_in;
   salsa_pkg::quad_type orig_ff;
   salsa_pkg::quad_type orig_in;
   salsa_pkg::quad_type stepped;
   salsa_pkg::quad_type permuted;
   salsa_pkg::quad_type loaded;
   salsa_pkg::quad_type finished;
   salsa_pkg::quad_type orig_rot;
   salsa_pkg::lane_type sum;
   logic [1:0]          rd_lane;
   logic [1:0]          rd_role;

   // Lane arithmetic and the fixed layout changes.
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         sum[l] = q_ff[l][0] + (ctrl.final_step ? orig_ff[l][0] : q_ff[l][3]);
         stepped[l][0] = q_ff[l][1] ^ salsa_pkg::rotl_sel(sum[l], ctrl.rot);
         stepped[l][1] = q_ff[l][2];
         stepped[l][2] = q_ff[l][3];
         stepped[l][3] = q_ff[l][0];
         finished[l][0] = q_ff[l][1];
         finished[l][1] = q_ff[l][2];
         finished[l][2] = q_ff[l][3];
         finished[l][3] = sum[l];
         orig_rot[l][0] = orig_ff[l][1];
         orig_rot[l][1] = orig_ff[l][2];
         orig_rot[l][2] = orig_ff[l][3];
         orig_rot[l][3] = orig_ff[l][0];
      end
      for (int l = 0; l < 4; l++) begin
         for (int r = 0; r < 4; r++) begin
            permuted[l][r] = stepped[(l + r) % 4][(4 - r) % 4];
            loaded[l][r]   = init_block[4 * ((l + r) % 4) + l];
         end
      end
   end

   // Next state of the lanes and of the saved starting state.
   always_comb begin
      q_in    = q_ff;
      orig_in = orig_ff;
      priority if (ctrl.load) begin
         q_in    = loaded;
         orig_in = loaded;
      end else if (ctrl.round_step) begin
         q_in = ctrl.permute ? permuted : stepped;
      end else if (ctrl.final_step) begin
         q_in    = finished;
         orig_in = orig_rot;
      end
   end

   always_ff @(posedge clock) begin
      q_ff    <= q_in;
      orig_ff <= orig_in;
   end

   // Keystream read: word p sits in lane p mod 4, role (p div 4 - lane) mod 4.
   assign rd_lane = rd_index[1:0];
   assign rd_role = rd_index[3:2] - rd_index[1:0];
   assign rd_word = salsa_pkg::bswap32(q_ff[rd_lane][rd_role]);

endmodule

`default_nettype wire

// ----- rtl/salsa_seq.sv -----
`default_nettype none

// Sequencer: 32 quarter round steps (eight half rounds of four steps), then
// four feed-forward steps, then the result transfer.
module salsa_seq (
   input  wire                        clock,
   input  wire                        reset,
   input  wire salsa_pkg::seq_in_type seq_in,
   output salsa_pkg::seq_out_type     seq_out,
   output salsa_pkg::core_ctrl_type   ctrl
);

   salsa_pkg::state_type state_ff;
   salsa_pkg::state_type state_in;
   logic [4:0]           cnt_ff;
   logic [4:0]           cnt_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         salsa_pkg::ST_IDLE: begin
            if (seq_in.accept) begin
               state_in = seq_in.need_build ? salsa_pkg::ST_ROUND : salsa_pkg::ST_EMIT;
            end
         end
         salsa_pkg::ST_ROUND: begin
            if (cnt_ff == 5'd31) begin
               state_in = salsa_pkg::ST_FINAL;
            end
         end
         salsa_pkg::ST_FINAL: begin
            if (cnt_ff[1:0] == 2'd3) begin
               state_in = salsa_pkg::ST_EMIT;
            end
         end
         salsa_pkg::ST_EMIT: begin
            if (seq_in.slot_free) begin
               state_in = salsa_pkg::ST_IDLE;
            end
         end
         default: state_in = salsa_pkg::ST_IDLE;
      endcase
   end

   // Step counter runs through the rounds and wraps into the final steps.
   always_comb begin
      if (state_ff == salsa_pkg::ST_ROUND || state_ff == salsa_pkg::ST_FINAL) begin
         cnt_in = cnt_ff + 5'd1;
      end else begin
         cnt_in = 5'd0;
      end
   end

   // Outputs.
   always_comb begin
      ctrl            = '0;
      ctrl.rot        = salsa_pkg::rot_type'(cnt_ff[1:0]);
      seq_out         = '0;
      seq_out.busy    = (state_ff != salsa_pkg::ST_IDLE);
      unique case (state_ff)
         salsa_pkg::ST_IDLE: begin
            ctrl.load = seq_in.accept && seq_in.need_build;
         end
         salsa_pkg::ST_ROUND: begin
            ctrl.round_step = 1'b1;
            ctrl.permute    = (cnt_ff[1:0] == 2'd3);
         end
         salsa_pkg::ST_FINAL: begin
            ctrl.final_step    = 1'b1;
            seq_out.block_done = (cnt_ff[1:0] == 2'd3);
         end
         salsa_pkg::ST_EMIT: begin
            seq_out.emit = seq_in.slot_free;
         end
         default: begin
            ctrl.load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= salsa_pkg::ST_IDLE;
         cnt_ff   <= 5'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/salsa20_8_stream_cipher.sv -----
`default_nettype none

// Channel   Ports                                        Direction  Carries
// req       req_valid, req_stall, req_text_word,         in         text word, restart flag
//           req_restart
// rsp       rsp_valid, rsp_stall, rsp_result_word        out        text word xor keystream
// csr       csr_psel .. csr_pready (64-bit data)         in/out     key mode, key, nonce
//
// A word that needs no new keystream block goes through the accepting
// transfer, then the loading of the output register. Word index zero (or
// a restart) builds a block first: quarter round steps, then feed-forward
// steps in the four-lane add-rotate-xor unit. A held output register does
// not stop the next word from being accepted; only its loading waits, and
// no other word is taken meanwhile. Reset clears the counter, index and control state.
module salsa20_8_stream_cipher (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [31:0] req_text_word,
   input  wire         req_restart,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [31:0] rsp_result_word,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [5:0]  csr_paddr,
   input  wire  [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   logic [1:0]  key_mode_ff;
   logic [63:0] key_01_ff;
   logic [63:0] key_23_ff;
   logic [63:0] key_45_ff;
   logic [63:0] key_67_ff;
   logic [63:0] nonce_ff;
   logic [2:0]  csr_index;
   logic        csr_write;

   logic [63:0] counter_ff;
   logic [63:0] counter_in;
   logic [63:0] counter_eff;
   logic [3:0]  index_ff;
   logic [3:0]  index_in;
   logic [31:0] text_ff;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [31:0] rsp_word_ff;
   logic [31:0] rsp_word_in;

   logic        accept;
   logic        need_build;

   salsa_pkg::word_type      k [8];
   salsa_pkg::word_type      c1;
   salsa_pkg::word_type      c2;
   salsa_pkg::block_type     init_block;
   salsa_pkg::word_type      rd_word;
   salsa_pkg::seq_in_type    seq_in;
   salsa_pkg::seq_out_type   seq_out;
   salsa_pkg::core_ctrl_type core_ctrl;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[5:3];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_mode_ff <= salsa_pkg::KEY_MODE_128;
         key_01_ff   <= 64'd0;
         key_23_ff   <= 64'd0;
         key_45_ff   <= 64'd0;
         key_67_ff   <= 64'd0;
         nonce_ff    <= 64'd0;
      end else if (csr_write) begin
         unique case (csr_index)
            salsa_pkg::REG_KEY_MODE: key_mode_ff <= csr_pwdata[1:0];
            salsa_pkg::REG_KEY_01:   key_01_ff   <= csr_pwdata;
            salsa_pkg::REG_KEY_23:   key_23_ff   <= csr_pwdata;
            salsa_pkg::REG_KEY_45:   key_45_ff   <= csr_pwdata;
            salsa_pkg::REG_KEY_67:   key_67_ff   <= csr_pwdata;
            salsa_pkg::REG_NONCE:    nonce_ff    <= csr_pwdata;
            default:                 key_mode_ff <= key_mode_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         salsa_pkg::REG_KEY_MODE: csr_prdata = {62'd0, key_mode_ff};
         salsa_pkg::REG_KEY_01:   csr_prdata = key_01_ff;
         salsa_pkg::REG_KEY_23:   csr_prdata = key_23_ff;
         salsa_pkg::REG_KEY_45:   csr_prdata = key_45_ff;
         salsa_pkg::REG_KEY_67:   csr_prdata = key_67_ff;
         salsa_pkg::REG_NONCE:    csr_prdata = nonce_ff;
         default:                 csr_prdata = 64'd0;
      endcase
   end

   // Input transfer; a restart or a zero index starts a new block.
   assign req_stall   = seq_out.busy;
   assign accept      = req_valid && !req_stall;
   assign need_build  = req_restart || (index_ff == 4'd0);
   assign counter_eff = req_restart ? 64'd0 : counter_ff;

   // Key words laid out by key mode. The unused mode code takes the
   // 128-bit layout.
   always_comb begin
      k[0] = key_01_ff[63:32];
      k[1] = key_01_ff[31:0];
      k[2] = key_23_ff[63:32];
      k[3] = key_23_ff[31:0];
      k[4] = key_45_ff[63:32];
      k[5] = key_45_ff[31:0];
      k[6] = key_67_ff[63:32];
      k[7] = key_67_ff[31:0];
      unique case (key_mode_ff)
         salsa_pkg::KEY_MODE_64: begin
            c1   = salsa_pkg::C1_64;
            c2   = salsa_pkg::C2_64;
            k[2] = k[0];
            k[3] = k[1];
            k[4] = k[0];
            k[5] = k[1];
            k[6] = k[0];
            k[7] = k[1];
         end
         salsa_pkg::KEY_MODE_256: begin
            c1 = salsa_pkg::C1_256;
            c2 = salsa_pkg::C2_256;
         end
         default: begin
            c1   = salsa_pkg::C1_128;
            c2   = salsa_pkg::C2_128;
            k[4] = k[0];
            k[5] = k[1];
            k[6] = k[2];
            k[7] = k[3];
         end
      endcase
   end

   // Starting state in matrix order; the counter enters unswapped.
   always_comb begin
      init_block[0]  = salsa_pkg::bswap32(salsa_pkg::SIGMA_0);
      init_block[1]  = salsa_pkg::bswap32(k[0]);
      init_block[2]  = salsa_pkg::bswap32(k[1]);
      init_block[3]  = salsa_pkg::bswap32(k[2]);
      init_block[4]  = salsa_pkg::bswap32(k[3]);
      init_block[5]  = salsa_pkg::bswap32(c1);
      init_block[6]  = salsa_pkg::bswap32(nonce_ff[63:32]);
      init_block[7]  = salsa_pkg::bswap32(nonce_ff[31:0]);
      init_block[8]  = counter_eff[31:0];
      init_block[9]  = counter_eff[63:32];
      init_block[10] = salsa_pkg::bswap32(c2);
      init_block[11] = salsa_pkg::bswap32(k[4]);
      init_block[12] = salsa_pkg::bswap32(k[5]);
      init_block[13] = salsa_pkg::bswap32(k[6]);
      init_block[14] = salsa_pkg::bswap32(k[7]);
      init_block[15] = salsa_pkg::bswap32(salsa_pkg::SIGMA_3);
   end

   assign seq_in = '{accept:     accept,
                     need_build: need_build,
                     slot_free:  !rsp_valid_ff || !rsp_stall};

   salsa_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .seq_in  (seq_in),
      .seq_out (seq_out),
      .ctrl    (core_ctrl)
   );

   salsa_core u_core (
      .clock      (clock),
      .ctrl       (core_ctrl),
      .init_block (init_block),
      .rd_index   (index_ff),
      .rd_word    (rd_word)
   );

   // Block counter and word index.
   always_comb begin
      counter_in = counter_ff;
      index_in   = index_ff;
      if (accept && req_restart) begin
         counter_in = 64'd0;
         index_in   = 4'd0;
      end
      if (seq_out.block_done) begin
         counter_in = counter_ff + 64'd1;
      end
      if (seq_out.emit) begin
         index_in = index_ff + 4'd1;
      end
   end

   // Output register: loaded when the word is ready and the slot is free.
   always_comb begin
      rsp_word_in = rsp_word_ff;
      if (seq_out.emit) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = text_ff ^ rd_word;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff   <= 64'd0;
         index_ff     <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         counter_ff   <= counter_in;
         index_ff     <= index_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         text_ff <= req_text_word;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_word = rsp_word_ff;

endmodule

`default_nettype wire

// ----- tb/sv/tb_salsa20_8_stream_cipher.sv -----
`timescale 1ns / 100ps

module tb_salsa20_8_stream_cipher;

   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned END_CYCLES = 40;
   localparam logic [1:0] KEY_MODE_UNUSED = 2'd3;

   // Rotation amounts of the four steps of a quarter round.
   localparam int unsigned SHIFT_B = 7;
   localparam int unsigned SHIFT_C = 9;
   localparam int unsigned SHIFT_D = 13;
   localparam int unsigned SHIFT_A = 18;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   wire         req_stall;
   logic [31:0] req_text_word = '0;
   logic        req_restart = 1'b0;
   wire         rsp_valid;
   logic        rsp_stall = 1'b0;
   wire  [31:0] rsp_result_word;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [5:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   wire  [63:0] csr_prdata;
   wire         csr_pready;

   // Mirror of the cipher's registers and keystream state.
   logic [1:0]          cfg_key_mode = salsa_pkg::KEY_MODE_128;
   logic [63:0]         cfg_key01 = '0;
   logic [63:0]         cfg_key23 = '0;
   logic [63:0]         cfg_key45 = '0;
   logic [63:0]         cfg_key67 = '0;
   logic [63:0]         cfg_nonce = '0;
   salsa_pkg::word_type keystream [16];
   logic [3:0]          ks_index = '0;
   logic [63:0]         ks_counter = '0;

   salsa_pkg::word_type expected_words [$];
   salsa_pkg::word_type head_word;
   int                  error_count = 0;
   int                  words_sent = 0;
   int                  restarts_sent = 0;
   int                  blocks_built = 0;
   int                  send_idle_pct = 36;
   int                  rsp_idle_pct = 60;
   int unsigned         quiet_cycles = 0;

   salsa20_8_stream_cipher DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_text_word   (req_text_word),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_word (rsp_result_word),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic salsa_pkg::word_type byte_rev(input salsa_pkg::word_type w);
      return {<<8{w}};
   endfunction

   function automatic salsa_pkg::word_type rotl(input salsa_pkg::word_type v,
                                                input int unsigned n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic salsa_pkg::block_type quarter_round(input salsa_pkg::block_type s,
                                                          input int a, input int b,
                                                          input int c, input int d);
      s[b] = s[b] ^ rotl(s[a] + s[d], SHIFT_B);
      s[c] = s[c] ^ rotl(s[b] + s[a], SHIFT_C);
      s[d] = s[d] ^ rotl(s[c] + s[b], SHIFT_D);
      s[a] = s[a] ^ rotl(s[d] + s[c], SHIFT_A);
      return s;
   endfunction

   // Builds the next 16-word keystream block from the key, nonce and counter.
   function automatic void refill_keystream();
      salsa_pkg::word_type  k [8];
      salsa_pkg::word_type  c1;
      salsa_pkg::word_type  c2;
      salsa_pkg::block_type s;
      salsa_pkg::block_type init;
      k[0] = cfg_key01[63:32];
      k[1] = cfg_key01[31:0];
      k[2] = cfg_key23[63:32];
      k[3] = cfg_key23[31:0];
      k[4] = cfg_key45[63:32];
      k[5] = cfg_key45[31:0];
      k[6] = cfg_key67[63:32];
      k[7] = cfg_key67[31:0];
      unique case (cfg_key_mode)
         salsa_pkg::KEY_MODE_64: begin
            c1 = salsa_pkg::C1_64;
            c2 = salsa_pkg::C2_64;
            for (int i = 2; i < 8; i++) k[i] = k[i % 2];
         end
         salsa_pkg::KEY_MODE_256: begin
            c1 = salsa_pkg::C1_256;
            c2 = salsa_pkg::C2_256;
         end
         default: begin
            c1 = salsa_pkg::C1_128;
            c2 = salsa_pkg::C2_128;
            for (int i = 4; i < 8; i++) k[i] = k[i - 4];
         end
      endcase
      s[0]  = byte_rev(salsa_pkg::SIGMA_0);
      s[1]  = byte_rev(k[0]);
      s[2]  = byte_rev(k[1]);
      s[3]  = byte_rev(k[2]);
      s[4]  = byte_rev(k[3]);
      s[5]  = byte_rev(c1);
      s[6]  = byte_rev(cfg_nonce[63:32]);
      s[7]  = byte_rev(cfg_nonce[31:0]);
      s[8]  = ks_counter[31:0];
      s[9]  = ks_counter[63:32];
      s[10] = byte_rev(c2);
      s[11] = byte_rev(k[4]);
      s[12] = byte_rev(k[5]);
      s[13] = byte_rev(k[6]);
      s[14] = byte_rev(k[7]);
      s[15] = byte_rev(salsa_pkg::SIGMA_3);
      init = s;
      // Four double rounds: columns first, then rows.
      for (int r = 0; r < 4; r++) begin
         s = quarter_round(s, 0, 4, 8, 12);
         s = quarter_round(s, 5, 9, 13, 1);
         s = quarter_round(s, 10, 14, 2, 6);
         s = quarter_round(s, 15, 3, 7, 11);
         s = quarter_round(s, 0, 1, 2, 3);
         s = quarter_round(s, 5, 6, 7, 4);
         s = quarter_round(s, 10, 11, 8, 9);
         s = quarter_round(s, 15, 12, 13, 14);
      end
      for (int i = 0; i < 16; i++) keystream[i] = byte_rev(s[i] + init[i]);
      ks_counter = ks_counter + 64'd1;
      blocks_built++;
   endfunction

   // Works out the ciphered word for one accepted text word.
   function automatic salsa_pkg::word_type predict_cipher(input salsa_pkg::word_type text,
                                                          input logic restart);
      salsa_pkg::word_type r;
      if (restart) begin
         ks_counter = '0;
         ks_index = '0;
      end
      if (ks_index == 4'd0) refill_keystream();
      r = text ^ keystream[ks_index];
      ks_index = ks_index + 4'd1;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("ERROR at %0t: %s: got %h, expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   // Writes one register over the configuration port and reads it back.
   task automatic write_and_check_reg(input logic [2:0] idx, input logic [63:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      unique case (idx)
         salsa_pkg::REG_KEY_MODE: cfg_key_mode = value[1:0];
         salsa_pkg::REG_KEY_01:   cfg_key01 = value;
         salsa_pkg::REG_KEY_23:   cfg_key23 = value;
         salsa_pkg::REG_KEY_45:   cfg_key45 = value;
         salsa_pkg::REG_KEY_67:   cfg_key67 = value;
         default:                 cfg_nonce = value;
      endcase
      // Read-back transfer straight after the write.
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == salsa_pkg::REG_KEY_MODE) begin
         if (csr_prdata[1:0] !== value[1:0])
            report_mismatch("key mode read-back", csr_prdata, value);
      end else if (csr_prdata !== value) begin
         report_mismatch("register read-back", csr_prdata, value);
      end
      // The port goes idle before the next transfer.
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [1:0] mode, input logic [63:0] k01,
                            input logic [63:0] k23, input logic [63:0] k45,
                            input logic [63:0] k67, input logic [63:0] nonce);
      write_and_check_reg(salsa_pkg::REG_KEY_MODE, {62'd0, mode});
      write_and_check_reg(salsa_pkg::REG_KEY_01, k01);
      write_and_check_reg(salsa_pkg::REG_KEY_23, k23);
      write_and_check_reg(salsa_pkg::REG_KEY_45, k45);
      write_and_check_reg(salsa_pkg::REG_KEY_67, k67);
      write_and_check_reg(salsa_pkg::REG_NONCE, nonce);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Offers one text word and waits for its transfer.
   task automatic send_word(input salsa_pkg::word_type text, input logic restart);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_text_word <= text;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      expected_words.push_back(predict_cipher(text, restart));
      words_sent++;
      if (restart) restarts_sent++;
   endtask

   // Holds the sender back until every expected word has come out.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Seventeen words from reset: field extremes and the wrap into a second block.
   task automatic test_index_wrap();
      send_word(32'h0000_0000, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      for (int i = 0; i < 15; i++) send_word($urandom, 1'b0);
      wait_for_results();
   endtask

   // One restarted word in each key layout, the unused code among them.
   task automatic test_key_modes();
      logic [1:0] modes [4];
      modes[0] = salsa_pkg::KEY_MODE_64;
      modes[1] = salsa_pkg::KEY_MODE_128;
      modes[2] = salsa_pkg::KEY_MODE_256;
      modes[3] = KEY_MODE_UNUSED;
      foreach (modes[m]) begin
         if (modes[m] == salsa_pkg::KEY_MODE_256)
            configure(modes[m], '1, '1, '1, '1, '1);
         else
            configure(modes[m], rand64(), rand64(), rand64(), rand64(), rand64());
         send_word($urandom, 1'b1);
         wait_for_results();
      end
   endtask

   // A change of key in the middle of a block must wait for the next build.
   task automatic test_mid_block_config();
      send_word($urandom, 1'b1);
      wait_for_results();
      configure(salsa_pkg::KEY_MODE_256, rand64(), rand64(), rand64(), rand64(), rand64());
      send_word($urandom, 1'b0);
      send_word($urandom, 1'b0);
      wait_for_results();
   endtask

   // Random words under one setting, with a full pause half way through.
   task automatic test_random_traffic(input int count, input int s_pct, input int r_pct,
                                      input logic [1:0] mode, input bit all_ones);
      send_idle_pct = s_pct;
      rsp_idle_pct = r_pct;
      if (all_ones)
         configure(mode, '1, '1, '1, '1, '1);
      else
         configure(mode, rand64(), rand64(), rand64(), rand64(), rand64());
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) wait_for_results();
         send_word($urandom, $urandom_range(0, 19) == 0);
      end
      wait_for_results();
   endtask

   // Receiver stall and checking of each result transfer.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               report_mismatch("result with none expected", {32'd0, rsp_result_word},
                               64'd0);
            end else begin
               head_word = expected_words.pop_front();
               if (rsp_result_word !== head_word)
                  report_mismatch("result_word", {32'd0, rsp_result_word},
                                  {32'd0, head_word});
            end
         end
      end
   end

   // Watchdog on cycles in which no transfer happens on any port.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles", quiet_cycles);
         $display("FAIL salsa20_8_stream_cipher");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_index_wrap();
      test_key_modes();
      test_mid_block_config();
      test_random_traffic(130, 36, 60, salsa_pkg::KEY_MODE_256, 1'b0);
      test_random_traffic(130, 60, 36, salsa_pkg::KEY_MODE_64, 1'b1);
      test_random_traffic(140, 0, 0, salsa_pkg::KEY_MODE_128, 1'b0);
      repeat (END_CYCLES) @(posedge clock);
      if (expected_words.size() != 0)
         report_mismatch("results never delivered", 64'(expected_words.size()), 64'd0);
      $display("Ran %0d words (%0d restarts) in all key layouts and the unused mode code,",
               words_sent, restarts_sent);
      $display("building %0d keystream blocks under sender and receiver back-pressure.",
               blocks_built);
      if (error_count == 0) begin
         $display("PASS salsa20_8_stream_cipher");
      end else begin
         $display("FAIL salsa20_8_stream_cipher");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/salsa_pkg.sv
rtl/salsa_core.sv
rtl/salsa_seq.sv
rtl/salsa20_8_stream_cipher.sv
tb/sv/tb_salsa20_8_stream_cipher.sv
